// ===== rtl/wpf_pkg.sv =====
// wpf_pkg: shared types, constants and tables for the waypoint follower
// depends on nothing; used by wpf_ctrl, wpf_datapath and the top level
`timescale 1ns / 1ps
package wpf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 64;
   localparam int CORDIC_STEPS = 18;
   localparam int ITER_W = 5;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ACC_W = 46;
   localparam logic [21:0] TWO_PI_Q16 = 22'd411775;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_TICK = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WP_TOL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GOAL_TOL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SPD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN = 3'd5;

   typedef enum logic [4:0] {
      S_IDLE, S_APPEND, S_CLEAR,
      S_ST_CHK, S_ST_RDA, S_ST_RDB, S_ST_CAPB, S_ST_MUL, S_ST_DEC,
      S_TK_CHK, S_TK_RD, S_TK_CAP, S_TK_MUL, S_TK_DEC,
      S_CORDIC_INIT, S_CORDIC, S_ANGLE, S_MUL_GAIN, S_MUL_K, S_SPEED, S_EMIT
   } state_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_DXX, MUL_DYY, MUL_TOL, MUL_ABX, MUL_ABY,
      MUL_DOTX, MUL_DOTY, MUL_GAIN, MUL_K
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE, ACC_D2, ACC_TOL2, ACC_SEG, ACC_DOT
   } acc_dst_type;

   typedef struct packed {
      logic              load_req;
      logic              clear_path;
      logic              append;
      logic              ct_zero;
      logic              ct_inc;
      logic              rd_next;
      logic              cap_a;
      logic              cap_b;
      mul_sel_type       mul_sel;
      acc_dst_type       acc_dst;
      logic              acc_add;
      logic              goal_tol;
      logic              cordic_init;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              angle;
      logic              speed;
      logic              zero_spd;
      logic              emit;
   } cmd_type;

   typedef struct packed {
      logic has_cur;
      logic has_next;
      logic can_append;
      logic st_skip;
      logic tk_reached;
   } status_type;

   function automatic logic [17:0] atan_lut(input logic [ITER_W-1:0] i);
      logic [17:0] v;
      case (i)
         5'd0: v = 18'd131072;
         5'd1: v = 18'd77376;
         5'd2: v = 18'd40884;
         5'd3: v = 18'd20753;
         5'd4: v = 18'd10417;
         5'd5: v = 18'd5213;
         5'd6: v = 18'd2607;
         5'd7: v = 18'd1304;
         5'd8: v = 18'd652;
         5'd9: v = 18'd326;
         5'd10: v = 18'd163;
         5'd11: v = 18'd81;
         5'd12: v = 18'd41;
         5'd13: v = 18'd20;
         5'd14: v = 18'd10;
         5'd15: v = 18'd5;
         5'd16: v = 18'd3;
         5'd17: v = 18'd1;
         default: v = 18'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== rtl/wpf_if.sv =====
// wpf_req_if and wpf_rsp_if: valid/ready channels of the waypoint follower
// no dependencies
`timescale 1ns / 1ps
interface wpf_req_if;
   logic               valid;
   logic               ready;
   logic        [1:0]  opcode;
   logic signed [19:0] robot_x;
   logic signed [19:0] robot_y;
   logic signed [15:0] robot_heading;
   logic signed [19:0] point_x;
   logic signed [19:0] point_y;

   modport source (output valid, opcode, robot_x, robot_y, robot_heading, point_x, point_y,
                   input ready);
   modport sink (input valid, opcode, robot_x, robot_y, robot_heading, point_x, point_y,
                 output ready);
endinterface

interface wpf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_speed;
   logic signed [15:0] right_speed;
   logic        [6:0]  target_index;
   logic               path_active;

   modport source (output valid, left_speed, right_speed, target_index, path_active,
                   input ready);
   modport sink (input valid, left_speed, right_speed, target_index, path_active,
                 output ready);
endinterface

// ===== rtl/wpf_ctrl.sv =====
// wpf_ctrl: sequencing state machine of the waypoint follower
// depends on wpf_pkg; drives commands into wpf_datapath
`timescale 1ns / 1ps
module wpf_ctrl
   import wpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_opcode,
   output logic       req_ready,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      cmd = '0;
      cmd.iter = cnt_ff;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      // shared multiply/accumulate schedule
      case (cnt_ff[2:0])
         3'd0: cmd.mul_sel = MUL_DXX;
         3'd1: begin
            cmd.mul_sel = MUL_DYY;
            cmd.acc_dst = ACC_D2;
         end
         3'd2: begin
            cmd.mul_sel = MUL_TOL;
            cmd.acc_dst = ACC_D2;
            cmd.acc_add = 1'b1;
         end
         3'd3: begin
            cmd.mul_sel = MUL_ABX;
            cmd.acc_dst = ACC_TOL2;
         end
         3'd4: begin
            cmd.mul_sel = MUL_ABY;
            cmd.acc_dst = ACC_SEG;
         end
         3'd5: begin
            cmd.mul_sel = MUL_DOTX;
            cmd.acc_dst = ACC_SEG;
            cmd.acc_add = 1'b1;
         end
         3'd6: begin
            cmd.mul_sel = MUL_DOTY;
            cmd.acc_dst = ACC_DOT;
         end
         default: begin
            cmd.acc_dst = ACC_DOT;
            cmd.acc_add = 1'b1;
         end
      endcase
      if (state_ff != S_ST_MUL && state_ff != S_TK_MUL) begin
         cmd.mul_sel = MUL_NONE;
         cmd.acc_dst = ACC_NONE;
         cmd.acc_add = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_opcode)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_APPEND: state_in = S_APPEND;
                  OP_START: state_in = S_ST_CHK;
                  default: state_in = S_TK_CHK;
               endcase
               if (req_opcode == OP_START) cmd.ct_zero = 1'b1;
            end
         end
         S_APPEND: begin
            cmd.append = status.can_append;
            state_in = S_IDLE;
         end
         S_CLEAR: begin
            cmd.clear_path = 1'b1;
            cmd.zero_spd = 1'b1;
            state_in = S_EMIT;
         end
         S_ST_CHK: state_in = status.has_next ? S_ST_RDA : S_IDLE;
         S_ST_RDA: state_in = S_ST_RDB;
         S_ST_RDB: begin
            cmd.cap_a = 1'b1;
            cmd.rd_next = 1'b1;
            state_in = S_ST_CAPB;
         end
         S_ST_CAPB: begin
            cmd.cap_b = 1'b1;
            cnt_in = '0;
            state_in = S_ST_MUL;
         end
         S_ST_MUL: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd7) state_in = S_ST_DEC;
         end
         S_ST_DEC: begin
            if (status.st_skip) begin
               cmd.ct_inc = 1'b1;
               state_in = S_ST_CHK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TK_CHK: begin
            if (status.has_cur) begin
               state_in = S_TK_RD;
            end else begin
               cmd.zero_spd = 1'b1;
               state_in = S_EMIT;
            end
         end
         S_TK_RD: state_in = S_TK_CAP;
         S_TK_CAP: begin
            cmd.cap_a = 1'b1;
            cnt_in = '0;
            state_in = S_TK_MUL;
         end
         S_TK_MUL: begin
            cmd.goal_tol = !status.has_next;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff[2:0] == 3'd3) state_in = S_TK_DEC;
         end
         S_TK_DEC: begin
            if (status.tk_reached) begin
               cmd.ct_inc = 1'b1;
               state_in = S_TK_CHK;
            end else begin
               state_in = S_CORDIC_INIT;
            end
         end
         S_CORDIC_INIT: begin
            cmd.cordic_init = 1'b1;
            cnt_in = '0;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ITER_W'(CORDIC_STEPS - 1)) state_in = S_ANGLE;
         end
         S_ANGLE: begin
            cmd.angle = 1'b1;
            state_in = S_MUL_GAIN;
         end
         S_MUL_GAIN: begin
            cmd.mul_sel = MUL_GAIN;
            state_in = S_MUL_K;
         end
         S_MUL_K: begin
            cmd.mul_sel = MUL_K;
            state_in = S_SPEED;
         end
         S_SPEED: begin
            cmd.speed = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ===== rtl/wpf_datapath.sv =====
// wpf_datapath: waypoint memory, settings, shared multiplier, cordic and speed logic
// depends on wpf_pkg; commanded by wpf_ctrl
`timescale 1ns / 1ps
module wpf_datapath
   import wpf_pkg::*;
#(
   parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic signed [19:0]    req_robot_x,
   input  logic signed [19:0]    req_robot_y,
   input  logic signed [15:0]    req_robot_heading,
   input  logic signed [19:0]    req_point_x,
   input  logic signed [19:0]    req_point_y,
   input  cmd_type               cmd,
   output status_type            status,
   output logic signed [15:0]    rsp_left_speed,
   output logic signed [15:0]    rsp_right_speed,
   output logic [6:0]            rsp_target_index,
   output logic                  rsp_path_active
);

   localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
   localparam int ADDR_W = $clog2(MAX_WAYPOINTS);

   logic [15:0] wp_tol_ff, goal_tol_ff, gain_ff;
   logic [13:0] cruise_ff;
   logic [14:0] turn_spd_ff, align_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_tol_ff <= 16'd200;
         goal_tol_ff <= 16'd100;
         cruise_ff <= 14'd500;
         turn_spd_ff <= 15'd300;
         gain_ff <= 16'd256;
         align_ff <= 15'd5461;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WP_TOL: wp_tol_ff <= csr_wdata;
            CSR_GOAL_TOL: goal_tol_ff <= csr_wdata;
            CSR_CRUISE: cruise_ff <= csr_wdata[13:0];
            CSR_TURN_SPD: turn_spd_ff <= csr_wdata[14:0];
            CSR_GAIN: gain_ff <= csr_wdata;
            CSR_ALIGN: align_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   logic signed [19:0] rx_ff, ry_ff, px_ff, py_ff;
   logic        [15:0] hd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         rx_ff <= req_robot_x;
         ry_ff <= req_robot_y;
         hd_ff <= req_robot_heading;
         px_ff <= req_point_x;
         py_ff <= req_point_y;
      end
   end

   // path bookkeeping
   logic [CNT_W-1:0] len_ff, ct_ff;
   logic [CNT_W:0]   ct_p1;

   assign ct_p1 = {1'b0, ct_ff} + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ct_ff <= '0;
      end else begin
         if (cmd.clear_path) begin
            len_ff <= '0;
            ct_ff <= '0;
         end else begin
            if (cmd.append) len_ff <= len_ff + 1'b1;
            if (cmd.ct_zero) ct_ff <= '0;
            else if (cmd.ct_inc) ct_ff <= ct_ff + 1'b1;
         end
      end
   end

   // waypoint memory
   logic [39:0]       mem [MAX_WAYPOINTS];
   logic [39:0]       rdata_ff;
   logic [ADDR_W-1:0] rd_addr;

   assign rd_addr = cmd.rd_next ? ADDR_W'(ct_p1) : ADDR_W'(ct_ff);

   always_ff @(posedge clock) begin
      if (cmd.append) mem[ADDR_W'(len_ff)] <= {px_ff, py_ff};
      rdata_ff <= mem[rd_addr];
   end

   logic signed [19:0] ax_ff, ay_ff, mx, my;
   logic signed [20:0] dxr_ff, dyr_ff, abx_ff, aby_ff;

   assign mx = rdata_ff[39:20];
   assign my = rdata_ff[19:0];

   always_ff @(posedge clock) begin
      if (cmd.cap_a) begin
         ax_ff <= mx;
         ay_ff <= my;
         dxr_ff <= 21'(rx_ff) - 21'(mx);
         dyr_ff <= 21'(ry_ff) - 21'(my);
      end
      if (cmd.cap_b) begin
         abx_ff <= 21'(mx) - 21'(ax_ff);
         aby_ff <= 21'(my) - 21'(ay_ff);
      end
   end

   // shared multiplier and accumulators
   logic signed [32:0]      mul_a;
   logic signed [21:0]      mul_b;
   logic signed [54:0]      prod_ff;
   logic signed [ACC_W-1:0] p, d2_ff, tol2_ff, seg_ff, dot_ff;
   logic        [15:0]      tol;
   logic        [15:0]      mag_ff;
   logic                    neg_ff;

   assign tol = cmd.goal_tol ? goal_tol_ff : wp_tol_ff;
   assign p = prod_ff[ACC_W-1:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_DXX: begin
            mul_a = 33'(dxr_ff);
            mul_b = 22'(dxr_ff);
         end
         MUL_DYY: begin
            mul_a = 33'(dyr_ff);
            mul_b = 22'(dyr_ff);
         end
         MUL_TOL: begin
            mul_a = {17'd0, tol};
            mul_b = {6'd0, tol};
         end
         MUL_ABX: begin
            mul_a = 33'(abx_ff);
            mul_b = 22'(abx_ff);
         end
         MUL_ABY: begin
            mul_a = 33'(aby_ff);
            mul_b = 22'(aby_ff);
         end
         MUL_DOTX: begin
            mul_a = 33'(dxr_ff);
            mul_b = 22'(abx_ff);
         end
         MUL_DOTY: begin
            mul_a = 33'(dyr_ff);
            mul_b = 22'(aby_ff);
         end
         MUL_GAIN: begin
            mul_a = {17'd0, gain_ff};
            mul_b = {6'd0, mag_ff};
         end
         MUL_K: begin
            mul_a = prod_ff[32:0];
            mul_b = TWO_PI_Q16;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.acc_dst)
         ACC_D2: d2_ff <= cmd.acc_add ? d2_ff + p : p;
         ACC_TOL2: tol2_ff <= p;
         ACC_SEG: seg_ff <= cmd.acc_add ? seg_ff + p : p;
         ACC_DOT: dot_ff <= cmd.acc_add ? dot_ff + p : p;
         default: ;
      endcase
   end

   // dot here is of (robot - a) with (b - a)
   logic signed [ACC_W+3:0] dot10, seg9;
   logic                    reached;

   assign dot10 = (50'(dot_ff) <<< 3) + (50'(dot_ff) <<< 1);
   assign seg9 = (50'(seg_ff) <<< 3) + 50'(seg_ff);
   assign reached = d2_ff <= tol2_ff;

   always_comb begin
      status.has_cur = ct_ff < len_ff;
      status.has_next = ct_p1 < {1'b0, len_ff};
      status.can_append = len_ff < CNT_W'(MAX_WAYPOINTS);
      status.st_skip = reached || (seg_ff < ACC_W'(100)) || (dot10 > seg9);
      status.tk_reached = reached;
   end

   // bearing by cordic vectoring
   logic signed [23:0] cx_ff, cy_ff, xs, ys;
   logic        [19:0] cz_ff, zr;
   logic        [15:0] u;

   assign xs = cx_ff >>> cmd.iter;
   assign ys = cy_ff >>> cmd.iter;

   always_ff @(posedge clock) begin
      if (cmd.cordic_init) begin
         if (dxr_ff > 0) begin
            cx_ff <= 24'(dxr_ff);
            cy_ff <= 24'(dyr_ff);
            cz_ff <= 20'h80000;
         end else begin
            cx_ff <= -24'(dxr_ff);
            cy_ff <= -24'(dyr_ff);
            cz_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         if (!cy_ff[23]) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + 20'(atan_lut(cmd.iter));
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - 20'(atan_lut(cmd.iter));
         end
      end
   end

   assign zr = cz_ff + 20'd8;
   assign u = zr[19:4] - hd_ff;

   always_ff @(posedge clock) begin
      if (cmd.angle) begin
         neg_ff <= u > 16'd32768;
         mag_ff <= (u > 16'd32768) ? (~u + 1'b1) : u;
      end
   end

   // wheel speeds
   logic        [50:0]      rnd;
   logic signed [17:0]      corr, cruise, lim, lraw, rraw;
   logic signed [15:0]      spd_l_ff, spd_r_ff;
   logic signed [15:0]      l_in, r_in;

   assign rnd = 51'(prod_ff[49:0]) + (51'd1 <<< 39);
   assign corr = neg_ff ? -18'(rnd[50:40]) : 18'(rnd[50:40]);
   assign cruise = 18'(cruise_ff);
   assign lim = 18'((17'(cruise_ff) * 17'd3) >> 1);
   assign lraw = cruise - corr;
   assign rraw = cruise + corr;

   always_comb begin
      if (mag_ff > 16'(align_ff)) begin
         l_in = neg_ff ? 16'(turn_spd_ff) : -16'(turn_spd_ff);
         r_in = neg_ff ? -16'(turn_spd_ff) : 16'(turn_spd_ff);
      end else begin
         if (lraw > lim) l_in = 16'(lim);
         else if (lraw < -lim) l_in = 16'(-lim);
         else l_in = 16'(lraw);
         if (rraw > lim) r_in = 16'(lim);
         else if (rraw < -lim) r_in = 16'(-lim);
         else r_in = 16'(rraw);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.zero_spd) begin
         spd_l_ff <= '0;
         spd_r_ff <= '0;
      end else if (cmd.speed) begin
         spd_l_ff <= l_in;
         spd_r_ff <= r_in;
      end
      if (cmd.emit) begin
         rsp_left_speed <= spd_l_ff;
         rsp_right_speed <= spd_r_ff;
         rsp_target_index <= 7'(ct_ff);
         rsp_path_active <= ct_ff < len_ff;
      end
   end

endmodule

// ===== rtl/waypoint_follower_diff_drive.sv =====
// waypoint_follower_diff_drive: top level of the differential drive waypoint follower
// depends on wpf_pkg, wpf_if, wpf_ctrl and wpf_datapath
// clear and tick raise a result, append and start do not; input is taken one beat at a time
// and ready returns when the operation ends; the shared multiplier and 18 cordic steps set
// the rate; a stalled result holds the next one back; synchronous reset restores default
// settings and an empty path
`timescale 1ns / 1ps
module waypoint_follower_diff_drive
   import wpf_pkg::*;
#(
   parameter int MAX_WAYPOINTS = MAX_WAYPOINTS_DEF
) (
   input logic                  clock,
   input logic                  reset,
   wpf_req_if.sink              req_ch,
   wpf_rsp_if.source            rsp_ch,
   input logic                  csr_we,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   wpf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_opcode (req_ch.opcode),
      .req_ready  (req_ch.ready),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .status     (status),
      .cmd        (cmd)
   );

   wpf_datapath #(
      .MAX_WAYPOINTS (MAX_WAYPOINTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_robot_x       (req_ch.robot_x),
      .req_robot_y       (req_ch.robot_y),
      .req_robot_heading (req_ch.robot_heading),
      .req_point_x       (req_ch.point_x),
      .req_point_y       (req_ch.point_y),
      .cmd               (cmd),
      .status            (status),
      .rsp_left_speed    (rsp_ch.left_speed),
      .rsp_right_speed   (rsp_ch.right_speed),
      .rsp_target_index  (rsp_ch.target_index),
      .rsp_path_active   (rsp_ch.path_active)
   );

endmodule

// ===== rtl/wpf_checker.sv =====
// wpf_checker: port level assertions for waypoint_follower_diff_drive
// depends on nothing; attached to the top level by bind
`timescale 1ns / 1ps
module wpf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] left_speed,
   input logic signed [15:0] right_speed,
   input logic              path_active
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one beat at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while busy");

   // idle path means stopped wheels
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !path_active |-> left_speed == 16'sd0 && right_speed == 16'sd0)
      else $error("wheels move without a path");

   // taking a new beat raises no result at once
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result raised right after accept");

endmodule

bind waypoint_follower_diff_drive wpf_checker u_wpf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .left_speed  (rsp_ch.left_speed),
   .right_speed (rsp_ch.right_speed),
   .path_active (rsp_ch.path_active)
);
